/* src/signed_binary_to_seven_segment_defines.svh */
// Assertion helpers for the seven-segment display block.
// Both expect i_clk and i_rst_n to be visible where they are used.
`ifndef SIGNED_BINARY_TO_SEVEN_SEGMENT_DEFINES_SVH
`define SIGNED_BINARY_TO_SEVEN_SEGMENT_DEFINES_SVH

// Same-cycle implication, off during reset.
`define SBSS_ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sbss assertion failed");

// Next-cycle implication, off during reset.
`define SBSS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sbss assertion failed");

`endif

/* src/sbss_pkg.sv */
package sbss_pkg;

    localparam int VALUE_W        = 32;
    localparam int SEG_W          = 7;
    localparam int DIGIT_W        = 4;
    localparam int MAX_DIGITS_DEF = 10;
    localparam int BIT_CNT_W      = $clog2(VALUE_W + 1);

    localparam logic [SEG_W-1:0]   SEG_MINUS = 7'h40;
    localparam logic [DIGIT_W-1:0] DIGIT_ZERO = 4'd0;

    // Control from the top-level sequencer to the glyph emitter
    typedef struct packed {
        logic load;
        logic negative;
    } t_emit_ctl;

    // Segment pattern of a decimal digit, bit0 = a ... bit6 = g
    function automatic logic [SEG_W-1:0] digit_glyph(input logic [DIGIT_W-1:0] d);
        logic [SEG_W-1:0] seg;
        unique case (d)
            4'd0:    seg = 7'h3F;
            4'd1:    seg = 7'h06;
            4'd2:    seg = 7'h5B;
            4'd3:    seg = 7'h4F;
            4'd4:    seg = 7'h66;
            4'd5:    seg = 7'h6D;
            4'd6:    seg = 7'h7D;
            4'd7:    seg = 7'h07;
            4'd8:    seg = 7'h7F;
            4'd9:    seg = 7'h6F;
            default: seg = 7'h00;
        endcase
        return seg;
    endfunction

    // Double-dabble correction of one BCD digit before the shift
    function automatic logic [DIGIT_W-1:0] dabble_fix(input logic [DIGIT_W-1:0] nib);
        return (nib >= 4'd5) ? nib + 4'd3 : nib;
    endfunction

endpackage

/* src/sbss_in_if.sv */
interface sbss_in_if;
    logic                               valid;
    logic                               ready;
    logic signed [sbss_pkg::VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

/* src/sbss_out_if.sv */
interface sbss_out_if;
    logic                          valid;
    logic                          ready;
    logic [sbss_pkg::SEG_W-1:0]    segments;
    logic                          is_sign;
    logic [sbss_pkg::DIGIT_W-1:0]  digit;
    logic                          last;

    modport source (output valid, output segments, output is_sign, output digit,
                    output last, input ready);
    modport sink   (input valid, input segments, input is_sign, input digit,
                    input last, output ready);
endinterface

/* src/sbss_dabble.sv */
module sbss_dabble #(
    parameter int MAX_DIGITS = sbss_pkg::MAX_DIGITS_DEF
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_load,
    input  logic [sbss_pkg::VALUE_W-1:0]             i_mag,
    output logic                                     o_busy,
    output logic [sbss_pkg::DIGIT_W*MAX_DIGITS-1:0]  o_bcd
);

    localparam int BCD_W = sbss_pkg::DIGIT_W * MAX_DIGITS;

    logic [sbss_pkg::VALUE_W-1:0]   r_bin, n_bin;
    logic [BCD_W-1:0]               r_bcd, n_bcd;
    logic [sbss_pkg::BIT_CNT_W-1:0] r_cnt, n_cnt;
    logic [BCD_W-1:0]               w_fix;

    // add-3 correction, each digit on its own
    for (genvar k = 0; k < MAX_DIGITS; k++) begin : g_fix
        assign w_fix[k*sbss_pkg::DIGIT_W +: sbss_pkg::DIGIT_W] =
            sbss_pkg::dabble_fix(r_bcd[k*sbss_pkg::DIGIT_W +: sbss_pkg::DIGIT_W]);
    end

    always_comb begin
        n_bin = r_bin;
        n_bcd = r_bcd;
        n_cnt = r_cnt;
        if (i_load) begin
            n_bin = i_mag;
            n_bcd = '0;
            n_cnt = sbss_pkg::BIT_CNT_W'(sbss_pkg::VALUE_W);
        end else if (r_cnt != '0) begin
            // carry out of the top digit is dropped: keeps the low digits only
            n_bcd = {w_fix[BCD_W-2:0], r_bin[sbss_pkg::VALUE_W-1]};
            n_bin = r_bin << 1;
            n_cnt = r_cnt - sbss_pkg::BIT_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_bin <= n_bin;
        r_bcd <= n_bcd;
    end

    assign o_busy = (r_cnt != '0);
    assign o_bcd  = r_bcd;

endmodule

/* src/sbss_emit.sv */
module sbss_emit #(
    parameter int MAX_DIGITS = sbss_pkg::MAX_DIGITS_DEF
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  sbss_pkg::t_emit_ctl                      i_ctl,
    input  logic [sbss_pkg::DIGIT_W*MAX_DIGITS-1:0]  i_bcd,
    output logic                                     o_active,
    sbss_out_if.source                               o_out
);

    localparam int BCD_W = sbss_pkg::DIGIT_W * MAX_DIGITS;
    localparam int REM_W = $clog2(MAX_DIGITS + 1);

    logic [BCD_W-1:0]               r_dig, n_dig;
    logic [REM_W-1:0]               r_rem, n_rem;
    logic                           r_sign, n_sign;
    logic                           r_lead, n_lead;
    logic                           r_valid, n_valid;
    logic [sbss_pkg::SEG_W-1:0]     r_seg, n_seg;
    logic                           r_is_sign, n_is_sign;
    logic [sbss_pkg::DIGIT_W-1:0]   r_digit, n_digit;
    logic                           r_last, n_last;

    logic                           w_space;
    logic [sbss_pkg::DIGIT_W-1:0]   w_top;
    logic                           w_final;
    logic                           w_skip;

    assign w_space = !r_valid || o_out.ready;
    assign w_top   = r_dig[BCD_W-1 -: sbss_pkg::DIGIT_W];
    assign w_final = (r_rem == REM_W'(1));
    // leading zero, but never the units digit
    assign w_skip  = r_lead && (w_top == sbss_pkg::DIGIT_ZERO) && !w_final;

    always_comb begin
        n_dig     = r_dig;
        n_rem     = r_rem;
        n_sign    = r_sign;
        n_lead    = r_lead;
        n_valid   = r_valid;
        n_seg     = r_seg;
        n_is_sign = r_is_sign;
        n_digit   = r_digit;
        n_last    = r_last;
        if (o_out.ready) begin
            n_valid = 1'b0;
        end
        if (i_ctl.load) begin
            n_dig  = i_bcd;
            n_rem  = REM_W'(MAX_DIGITS);
            n_sign = i_ctl.negative;
            n_lead = 1'b1;
        end else if (w_space && (r_sign || r_rem != '0)) begin
            if (r_sign) begin
                n_sign    = 1'b0;
                n_valid   = 1'b1;
                n_seg     = sbss_pkg::SEG_MINUS;
                n_is_sign = 1'b1;
                n_digit   = sbss_pkg::DIGIT_ZERO;
                n_last    = 1'b0;
            end else begin
                n_dig = r_dig << sbss_pkg::DIGIT_W;
                n_rem = r_rem - REM_W'(1);
                if (!w_skip) begin
                    n_lead    = 1'b0;
                    n_valid   = 1'b1;
                    n_seg     = sbss_pkg::digit_glyph(w_top);
                    n_is_sign = 1'b0;
                    n_digit   = w_top;
                    n_last    = w_final;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem   <= '0;
            r_sign  <= 1'b0;
            r_lead  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_rem   <= n_rem;
            r_sign  <= n_sign;
            r_lead  <= n_lead;
            r_valid <= n_valid;
        end
        r_dig     <= n_dig;
        r_seg     <= n_seg;
        r_is_sign <= n_is_sign;
        r_digit   <= n_digit;
        r_last    <= n_last;
    end

    assign o_active       = r_sign || (r_rem != '0);
    assign o_out.valid    = r_valid;
    assign o_out.segments = r_seg;
    assign o_out.is_sign  = r_is_sign;
    assign o_out.digit    = r_digit;
    assign o_out.last     = r_last;

endmodule

/* src/signed_binary_to_seven_segment.sv */
// Signed binary to seven-segment glyph stream. One signed 32-bit value goes
// in; out come one glyph per item: a minus glyph first when the value is
// negative, then the decimal digits of the magnitude, most significant first,
// leading zeros dropped (zero shows a single '0'), the final glyph flagged
// with last. The most negative value displays as 2147483648. Only the low
// MAX_DIGITS decimal digits are kept. Segment bits are a..g in bits 0..6.
// The block takes one value at a time. It runs a bit-serial double-dabble
// converter, one shift per input bit, followed by the emitter, which walks the
// BCD register one digit per cycle while the output is not stalled, skipping
// leading zeros in place. The next value is accepted once the emitter has
// run out of digits and the sequencer has gone back to idle, even if the last
// glyph has not been taken yet.
module signed_binary_to_seven_segment #(
    parameter int MAX_DIGITS = sbss_pkg::MAX_DIGITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sbss_in_if.sink     i_in,
    sbss_out_if.source  o_out
);

    localparam int BCD_W = sbss_pkg::DIGIT_W * MAX_DIGITS;

    // sequencer: wait for a value, convert, stream glyphs
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CONV = 3'b010,
        ST_EMIT = 3'b100
    } t_state;

    t_state                       r_state, n_state;
    logic                         r_neg, n_neg;
    logic                         w_accept;
    logic [sbss_pkg::VALUE_W-1:0] w_raw;
    logic [sbss_pkg::VALUE_W-1:0] w_mag;
    logic                         w_busy;
    logic                         w_active;
    logic [BCD_W-1:0]             w_bcd;
    sbss_pkg::t_emit_ctl          w_ctl;

    assign i_in.ready = (r_state == ST_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;

    // magnitude as unsigned, so the most negative value keeps its top bit
    assign w_raw = i_in.value;
    assign w_mag = w_raw[sbss_pkg::VALUE_W-1] ? (~w_raw + sbss_pkg::VALUE_W'(1)) : w_raw;

    always_comb begin
        n_state = r_state;
        n_neg   = r_neg;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_CONV;
                    n_neg   = w_raw[sbss_pkg::VALUE_W-1];
                end
            end
            ST_CONV: begin
                if (!w_busy) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!w_active) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // hand the finished BCD word to the emitter as conversion ends
    assign w_ctl.load     = (r_state == ST_CONV) && !w_busy;
    assign w_ctl.negative = r_neg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_neg <= n_neg;
    end

    sbss_dabble #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dabble (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_accept),
        .i_mag   (w_mag),
        .o_busy  (w_busy),
        .o_bcd   (w_bcd)
    );

    sbss_emit #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_emit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_bcd    (w_bcd),
        .o_active (w_active),
        .o_out    (o_out)
    );

endmodule

/* src/sbss_checker.sv */
`include "signed_binary_to_seven_segment_defines.svh"

module sbss_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [sbss_pkg::SEG_W-1:0]    i_out_segments,
    input logic                          i_out_is_sign,
    input logic [sbss_pkg::DIGIT_W-1:0]  i_out_digit,
    input logic                          i_out_last
);

    logic [sbss_pkg::SEG_W+sbss_pkg::DIGIT_W+1:0] w_out_word;
    logic                                         w_sign_ok;
    logic                                         w_digit_ok;

    assign w_out_word = {i_out_segments, i_out_is_sign, i_out_digit, i_out_last};
    assign w_sign_ok  = (i_out_segments == sbss_pkg::SEG_MINUS) &&
                        (i_out_digit == sbss_pkg::DIGIT_ZERO) && !i_out_last;
    assign w_digit_ok = (i_out_digit <= 4'd9) &&
                        (i_out_segments == sbss_pkg::digit_glyph(i_out_digit));

    // stalled glyph holds still
    `SBSS_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(w_out_word))

    // one value at a time: no second accept right behind the first
    `SBSS_ASSERT_NEXT(a_busy_after_accept, i_in_valid && i_in_ready, !i_in_ready)

    // minus glyph is g only, digit zero, never the final glyph
    `SBSS_ASSERT_IMPLIES(a_sign_glyph, i_out_valid && i_out_is_sign, w_sign_ok)

    // digit glyphs are decimal and match the segment table
    `SBSS_ASSERT_IMPLIES(a_digit_glyph, i_out_valid && !i_out_is_sign, w_digit_ok)

endmodule

bind signed_binary_to_seven_segment sbss_checker u_sbss_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_segments (o_out.segments),
    .i_out_is_sign  (o_out.is_sign),
    .i_out_digit    (o_out.digit),
    .i_out_last     (o_out.last)
);
